// ===== sv/mtep_pkg.sv =====
// shared types and constants of the midi track event parser
`default_nettype none
package mtep_pkg;

    localparam int NKEYS            = 2048;
    localparam int KEY_W            = 11;
    localparam int NOTE_QUEUE_DEPTH = 2;
    localparam int VARLEN_MAX_BYTES = 4;
    localparam int SLOT_W           = 39;

    localparam logic [7:0] DATA_MASK   = 8'h7f;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_PROGRAM  = 8'hc0;
    localparam logic [7:0] ST_SYSEX    = 8'hf0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hf7;
    localparam logic [7:0] ST_META     = 8'hff;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_EOT    = 8'h2f;

    typedef enum logic [3:0] {
        PH_DELTA  = 4'd0,
        PH_STATUS = 4'd1,
        PH_DATA1  = 4'd2,
        PH_DATA2  = 4'd3,
        PH_MTYPE  = 4'd4,
        PH_MLEN   = 4'd5,
        PH_MDATA  = 4'd6,
        PH_SLEN   = 4'd7,
        PH_SDATA  = 4'd8,
        PH_IDLE   = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NOTE  = 2'd0,
        KIND_TEMPO = 2'd1,
        KIND_EOT   = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_LONG_VLQ  = 3'd1,
        ERR_TRUNCATED = 3'd2,
        ERR_NO_STATUS = 3'd3,
        ERR_SYSTEM    = 3'd4,
        ERR_QUEUE     = 3'd5
    } t_err;

endpackage
`default_nettype wire

// ===== sv/mtep_if.sv =====
// stream interfaces for track bytes and parsed events
`default_nettype none
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       track_start;
    logic       track_end;
    modport source (output valid, data_byte, track_start, track_end, input ready);
    modport sink   (input valid, data_byte, track_start, track_end, output ready);
endinterface

interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] start_tick;
    logic [31:0] duration_ticks;
    logic [3:0]  channel_number;
    logic [6:0]  note_number;
    logic [6:0]  velocity;
    logic [23:0] tempo_micros;
    logic [2:0]  fault_code;
    logic        last_of_run;
    modport source (output valid, kind, start_tick, duration_ticks, channel_number,
                    note_number, velocity, tempo_micros, fault_code, last_of_run,
                    input ready);
    modport sink   (input valid, kind, start_tick, duration_ticks, channel_number,
                    note_number, velocity, tempo_micros, fault_code, last_of_run,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/mtep_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module mtep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

// ===== sv/midi_track_event_parser_core.sv =====
// top level: track byte parser with per channel-and-key note queues in ram
//
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   data_byte, track_start, track_end
//  o_out    out  valid/ready   kind, ticks, note fields, tempo, fault_code, last_of_run
//
// one byte per cycle when ready; a byte leaves at most one event, the cycle after.
// the count ram is read one byte ahead (when the key byte lands) so the
// velocity byte updates it in its own cycle; the slot ram read feeds the output.
// after reset, and before a track-start byte is taken, a clearing pass writes
// all 2048 count entries; input ready stays low from the start until the last write.
// a stalled output holds ready low on the input; nothing is dropped.
`default_nettype none
module midi_track_event_parser_core #(
    parameter int NOTE_QUEUE_DEPTH = mtep_pkg::NOTE_QUEUE_DEPTH
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    mtep_in_if.sink    i_in,
    mtep_out_if.source o_out
);
    localparam int D        = NOTE_QUEUE_DEPTH;
    localparam int CW       = $clog2(D + 1);
    localparam int HW       = (D > 1) ? $clog2(D) : 1;
    localparam int SW       = CW + 1;
    localparam int CEW      = CW + HW;
    localparam int SDEPTH   = mtep_pkg::NKEYS * D;
    localparam int SAW      = $clog2(SDEPTH);
    localparam int KW       = mtep_pkg::KEY_W;
    localparam int SLOT_W_L = mtep_pkg::SLOT_W;

    // parse state
    mtep_pkg::t_phase r_phase, e_phase, n_phase, p_phase;
    logic [31:0] r_tick, e_tick, n_tick;
    logic [7:0]  r_rs, e_rs, n_rs;
    logic [27:0] r_vacc, e_vacc, n_vacc;
    logic [2:0]  r_vcnt, e_vcnt, n_vcnt;
    logic [27:0] r_skip, e_skip, n_skip;
    logic [7:0]  r_meta, e_meta, n_meta;
    logic [7:0]  r_evst, e_evst, n_evst;
    logic [6:0]  r_fd, e_fd, n_fd;
    logic [23:0] r_tg, e_tg, n_tg;

    // clearing pass
    logic          r_clearing, r_need_clr, r_clean;
    logic [KW-1:0] r_clr_addr;
    logic          clr_start;

    // output stage
    logic                r_b_valid;
    mtep_pkg::t_kind     r_b_kind;
    mtep_pkg::t_err      r_b_err;
    logic [31:0]         r_b_tick;
    logic [23:0]         r_b_tempo;
    logic [3:0]          r_b_ch;
    logic [6:0]          r_b_key;

    logic accept, out_xfer;
    logic [7:0] b;
    logic ts, te;

    // varlen helpers
    logic [27:0] vl_acc;
    logic [2:0]  vl_cnt;
    logic        vl_done, vl_long;
    logic [7:0]  mlen_meta;
    logic [23:0] md_tg;
    logic [27:0] skip_dec;

    // note store access
    logic [KW-1:0]  idx;
    logic [3:0]     ev;
    logic [6:0]     second;
    logic           note_on, note_off, note_full, cd_event;
    logic [CEW-1:0] cnt_q;
    logic [CW-1:0]  cnt;
    logic [HW-1:0]  head, head_inc, pos;
    logic [SW-1:0]  pos_sum;
    logic [SAW-1:0] slot_base;
    logic [SLOT_W_L-1:0] slot_q;

    // outputs of the parse cycle
    logic           res_valid;
    mtep_pkg::t_kind res_kind;
    mtep_pkg::t_err res_err;
    logic [31:0]    res_tick;
    logic [23:0]    res_tempo;
    logic           cnt_we, slot_we, slot_re;
    logic [CEW-1:0] cnt_wdata;
    logic [SAW-1:0] slot_addr;

    logic           cram_we;
    logic [KW-1:0]  cram_waddr;
    logic [CEW-1:0] cram_wdata;

    logic [31:0] dur_raw;

    assign b  = i_in.data_byte;
    assign ts = i_in.track_start;
    assign te = i_in.track_end;

    assign i_in.ready = !r_clearing && !r_need_clr && (!ts || r_clean)
                        && (!r_b_valid || o_out.ready);
    assign accept   = i_in.valid && i_in.ready;
    assign out_xfer = r_b_valid && o_out.ready;
    assign clr_start = !r_clearing && (r_need_clr || (i_in.valid && ts && !r_clean));

    // state as seen by the byte, after a track start clears it
    always_comb begin
        if (ts) begin
            e_phase = mtep_pkg::PH_DELTA;
            e_tick  = '0;
            e_rs    = '0;
            e_vacc  = '0;
            e_vcnt  = '0;
            e_skip  = '0;
            e_meta  = '0;
            e_evst  = '0;
            e_fd    = '0;
            e_tg    = '0;
        end else begin
            e_phase = r_phase;
            e_tick  = r_tick;
            e_rs    = r_rs;
            e_vacc  = r_vacc;
            e_vcnt  = r_vcnt;
            e_skip  = r_skip;
            e_meta  = r_meta;
            e_evst  = r_evst;
            e_fd    = r_fd;
            e_tg    = r_tg;
        end
    end

    assign vl_acc   = {e_vacc[20:0], b[6:0]};
    assign vl_cnt   = e_vcnt + 3'd1;
    assign vl_done  = !b[7];
    assign vl_long  = b[7] && (vl_cnt >= 3'(mtep_pkg::VARLEN_MAX_BYTES));
    assign mlen_meta = (e_meta == mtep_pkg::META_TEMPO && vl_acc != 28'd3) ? 8'd0 : e_meta;
    assign md_tg    = {e_tg[15:0], b};
    assign skip_dec = e_skip - 28'd1;

    assign idx      = {e_evst[3:0], e_fd};
    assign ev       = e_evst[7:4];
    assign second   = b[6:0] & mtep_pkg::DATA_MASK[6:0];
    assign cd_event = (e_evst[7:5] == mtep_pkg::ST_PROGRAM[7:5]);
    assign note_on  = (ev == mtep_pkg::ST_NOTE_ON[7:4]) && (second != 7'd0);
    assign note_off = (ev == mtep_pkg::ST_NOTE_OFF[7:4])
                      || ((ev == mtep_pkg::ST_NOTE_ON[7:4]) && (second == 7'd0));
    assign cnt      = cnt_q[CW-1:0];
    assign head     = cnt_q[CEW-1:CW];
    assign note_full = (cnt >= CW'(D));
    assign pos_sum  = SW'(cnt) + SW'(head);
    assign pos      = (pos_sum >= SW'(D)) ? HW'(pos_sum - SW'(D)) : HW'(pos_sum);
    assign head_inc = (head == HW'(D - 1)) ? '0 : head + HW'(1);
    assign slot_base = SAW'(idx) * SAW'(D);

    // next state
    always_comb begin
        p_phase = e_phase;
        n_tick  = e_tick;
        n_rs    = e_rs;
        n_vacc  = e_vacc;
        n_vcnt  = e_vcnt;
        n_skip  = e_skip;
        n_meta  = e_meta;
        n_evst  = e_evst;
        n_fd    = e_fd;
        n_tg    = e_tg;
        case (e_phase)
            mtep_pkg::PH_DELTA: begin
                n_vacc = vl_acc;
                n_vcnt = vl_cnt;
                if (vl_long) begin
                    p_phase = mtep_pkg::PH_IDLE;
                end else if (vl_done) begin
                    n_tick  = e_tick + {4'd0, vl_acc};
                    n_vacc  = '0;
                    n_vcnt  = '0;
                    p_phase = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (!b[7]) begin
                    if (e_rs == 8'd0) begin
                        p_phase = mtep_pkg::PH_IDLE;
                    end else begin
                        n_evst  = e_rs;
                        n_fd    = b[6:0];
                        p_phase = (e_rs[7:5] == mtep_pkg::ST_PROGRAM[7:5])
                                  ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
                    end
                end else if (b < mtep_pkg::ST_SYSEX) begin
                    n_rs    = b;
                    n_evst  = b;
                    p_phase = mtep_pkg::PH_DATA1;
                end else if (b == mtep_pkg::ST_META) begin
                    n_rs    = '0;
                    p_phase = mtep_pkg::PH_MTYPE;
                end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
                    n_rs    = '0;
                    p_phase = mtep_pkg::PH_SLEN;
                end else begin
                    p_phase = mtep_pkg::PH_IDLE;
                end
            end
            mtep_pkg::PH_DATA1: begin
                n_fd    = b[6:0];
                p_phase = cd_event ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
            end
            mtep_pkg::PH_DATA2: begin
                p_phase = (note_on && note_full) ? mtep_pkg::PH_IDLE : mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_MTYPE: begin
                n_meta  = b;
                p_phase = mtep_pkg::PH_MLEN;
            end
            mtep_pkg::PH_MLEN: begin
                n_vacc = vl_acc;
                n_vcnt = vl_cnt;
                if (vl_long) begin
                    p_phase = mtep_pkg::PH_IDLE;
                end else if (vl_done) begin
                    n_skip = vl_acc;
                    n_vacc = '0;
                    n_vcnt = '0;
                    n_meta = mlen_meta;
                    n_tg   = '0;
                    if (vl_acc == 28'd0) begin
                        p_phase = (mlen_meta == mtep_pkg::META_EOT) ? mtep_pkg::PH_IDLE
                                                                    : mtep_pkg::PH_DELTA;
                    end else begin
                        p_phase = mtep_pkg::PH_MDATA;
                    end
                end
            end
            mtep_pkg::PH_MDATA: begin
                n_tg   = md_tg;
                n_skip = skip_dec;
                if (skip_dec == 28'd0) begin
                    p_phase = (e_meta == mtep_pkg::META_EOT) ? mtep_pkg::PH_IDLE
                                                             : mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_SLEN: begin
                n_vacc = vl_acc;
                n_vcnt = vl_cnt;
                if (vl_long) begin
                    p_phase = mtep_pkg::PH_IDLE;
                end else if (vl_done) begin
                    n_skip  = vl_acc;
                    n_vacc  = '0;
                    n_vcnt  = '0;
                    p_phase = (vl_acc == 28'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SDATA;
                end
            end
            mtep_pkg::PH_SDATA: begin
                n_skip = skip_dec;
                if (skip_dec == 28'd0) begin
                    p_phase = mtep_pkg::PH_DELTA;
                end
            end
            default: begin
                p_phase = mtep_pkg::PH_IDLE;
            end
        endcase
        n_phase = te ? mtep_pkg::PH_IDLE : p_phase;
    end

    // results and note store accesses
    always_comb begin
        res_valid = 1'b0;
        res_kind  = mtep_pkg::KIND_ERROR;
        res_err   = mtep_pkg::ERR_NONE;
        res_tick  = '0;
        res_tempo = '0;
        cnt_we    = 1'b0;
        cnt_wdata = cnt_q;
        slot_we   = 1'b0;
        slot_re   = 1'b0;
        slot_addr = slot_base + SAW'(head);
        case (e_phase)
            mtep_pkg::PH_DELTA, mtep_pkg::PH_SLEN: begin
                if (vl_long) begin
                    res_valid = 1'b1;
                    res_err   = mtep_pkg::ERR_LONG_VLQ;
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (!b[7] && e_rs == 8'd0) begin
                    res_valid = 1'b1;
                    res_err   = mtep_pkg::ERR_NO_STATUS;
                end else if (b[7] && b >= mtep_pkg::ST_SYSEX && b != mtep_pkg::ST_META
                             && b != mtep_pkg::ST_SYSEX && b != mtep_pkg::ST_SYSEX_ESC) begin
                    res_valid = 1'b1;
                    res_err   = mtep_pkg::ERR_SYSTEM;
                end
            end
            mtep_pkg::PH_DATA2: begin
                if (note_on) begin
                    if (note_full) begin
                        res_valid = 1'b1;
                        res_err   = mtep_pkg::ERR_QUEUE;
                    end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = {head, cnt + CW'(1)};
                        slot_we   = 1'b1;
                        slot_addr = slot_base + SAW'(pos);
                    end
                end else if (note_off && cnt != '0) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = {head_inc, cnt - CW'(1)};
                    slot_re   = 1'b1;
                    res_valid = 1'b1;
                    res_kind  = mtep_pkg::KIND_NOTE;
                    res_tick  = e_tick;
                end
            end
            mtep_pkg::PH_MLEN: begin
                if (vl_long) begin
                    res_valid = 1'b1;
                    res_err   = mtep_pkg::ERR_LONG_VLQ;
                end else if (vl_done && vl_acc == 28'd0 && mlen_meta == mtep_pkg::META_EOT) begin
                    res_valid = 1'b1;
                    res_kind  = mtep_pkg::KIND_EOT;
                    res_tick  = e_tick;
                end
            end
            mtep_pkg::PH_MDATA: begin
                if (skip_dec == 28'd0) begin
                    if (e_meta == mtep_pkg::META_TEMPO) begin
                        res_valid = 1'b1;
                        res_kind  = mtep_pkg::KIND_TEMPO;
                        res_tick  = e_tick;
                        res_tempo = md_tg;
                    end else if (e_meta == mtep_pkg::META_EOT) begin
                        res_valid = 1'b1;
                        res_kind  = mtep_pkg::KIND_EOT;
                        res_tick  = e_tick;
                    end
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
        // truncated event on the last byte of the chunk
        if (te && p_phase != mtep_pkg::PH_IDLE
            && !(p_phase == mtep_pkg::PH_DELTA && n_vcnt == 3'd0)) begin
            res_valid = 1'b1;
            res_kind  = mtep_pkg::KIND_ERROR;
            res_err   = mtep_pkg::ERR_TRUNCATED;
            res_tick  = '0;
            res_tempo = '0;
        end
    end

    assign cram_we    = r_clearing || (accept && cnt_we);
    assign cram_waddr = r_clearing ? r_clr_addr : idx;
    assign cram_wdata = r_clearing ? '0 : cnt_wdata;

    // count read runs one byte ahead, on the key that the next byte will use
    mtep_ram #(.WIDTH(CEW), .DEPTH(mtep_pkg::NKEYS)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cram_we),
        .i_waddr (cram_waddr),
        .i_wdata (cram_wdata),
        .i_re    (accept),
        .i_raddr ({n_evst[3:0], n_fd}),
        .o_rdata (cnt_q)
    );

    mtep_ram #(.WIDTH(SLOT_W_L), .DEPTH(SDEPTH)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (accept && slot_we),
        .i_waddr (slot_addr),
        .i_wdata ({second, e_tick}),
        .i_re    (accept && slot_re),
        .i_raddr (slot_addr),
        .o_rdata (slot_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mtep_pkg::PH_DELTA;
            r_tick     <= '0;
            r_rs       <= '0;
            r_vacc     <= '0;
            r_vcnt     <= '0;
            r_skip     <= '0;
            r_meta     <= '0;
            r_evst     <= '0;
            r_fd       <= '0;
            r_tg       <= '0;
            r_clearing <= 1'b0;
            r_need_clr <= 1'b1;
            r_clean    <= 1'b0;
            r_clr_addr <= '0;
            r_b_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_rs    <= n_rs;
                r_vacc  <= n_vacc;
                r_vcnt  <= n_vcnt;
                r_skip  <= n_skip;
                r_meta  <= n_meta;
                r_evst  <= n_evst;
                r_fd    <= n_fd;
                r_tg    <= n_tg;
                r_clean <= 1'b0;
            end
            if (clr_start) begin
                r_clearing <= 1'b1;
                r_need_clr <= 1'b0;
                r_clr_addr <= '0;
            end else if (r_clearing) begin
                r_clr_addr <= r_clr_addr + KW'(1);
                if (r_clr_addr == KW'(mtep_pkg::NKEYS - 1)) begin
                    r_clearing <= 1'b0;
                    r_clean    <= 1'b1;
                end
            end
            if (accept) begin
                r_b_valid <= res_valid;
            end else if (out_xfer) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_kind  <= res_kind;
            r_b_err   <= res_err;
            r_b_tick  <= res_tick;
            r_b_tempo <= res_tempo;
            r_b_ch    <= e_evst[3:0];
            r_b_key   <= e_fd;
        end
    end

    assign dur_raw = r_b_tick - slot_q[31:0];

    always_comb begin
        o_out.valid          = r_b_valid;
        o_out.kind           = r_b_kind;
        o_out.fault_code     = r_b_err;
        o_out.tempo_micros   = r_b_tempo;
        o_out.last_of_run    = 1'b1;
        if (r_b_kind == mtep_pkg::KIND_NOTE) begin
            o_out.start_tick     = slot_q[31:0];
            o_out.duration_ticks = (dur_raw == 32'd0) ? 32'd1 : dur_raw;
            o_out.channel_number = r_b_ch;
            o_out.note_number    = r_b_key;
            o_out.velocity       = slot_q[38:32];
        end else begin
            o_out.start_tick     = r_b_tick;
            o_out.duration_ticks = '0;
            o_out.channel_number = '0;
            o_out.note_number    = '0;
            o_out.velocity       = '0;
        end
    end
endmodule
`default_nettype wire

// ===== tb/midi_track_event_parser_core_test.sv =====
// testbench: random and directed track bytes checked against a behavioral parser
`timescale 1ns / 100ps
`default_nettype none
module midi_track_event_parser_core_test;

    typedef struct packed {
        mtep_pkg::t_kind kind;
        logic [31:0]     start_tick;
        logic [31:0]     duration;
        logic [3:0]      channel;
        logic [6:0]      key;
        logic [6:0]      velocity;
        logic [23:0]     tempo;
        mtep_pkg::t_err  err;
        logic            last;
    } t_event;

    typedef struct packed {
        logic [7:0] b;
        logic       ts;
        logic       te;
    } t_byte;

    class track_scoreboard;
        mtep_pkg::t_phase phase;
        logic [31:0] tick;
        logic [7:0]  run_status;
        logic [7:0]  meta_kind;
        logic [7:0]  ev_status;
        logic [6:0]  key_byte;
        logic [27:0] vlq_acc;
        int          vlq_cnt;
        logic [27:0] skip_left;
        logic [23:0] tempo_acc;
        logic [38:0] slots [4096];
        int          slot_cnt [2048];
        t_event      pending_events [$];
        t_event      byte_events [$];
        int          errors;

        function void clear_track();
            phase = mtep_pkg::PH_DELTA;
            tick = 0;
            run_status = 0;
            meta_kind = 0;
            ev_status = 0;
            key_byte = 0;
            vlq_acc = 0;
            vlq_cnt = 0;
            skip_left = 0;
            tempo_acc = 0;
            foreach (slot_cnt[i]) slot_cnt[i] = 0;
        endfunction

        function void emit(mtep_pkg::t_kind k, logic [31:0] st, logic [31:0] d,
                           logic [3:0] ch, logic [6:0] key, logic [6:0] vel,
                           logic [23:0] tp, mtep_pkg::t_err e);
            t_event ev;
            ev.kind = k; ev.start_tick = st; ev.duration = d; ev.channel = ch;
            ev.key = key; ev.velocity = vel; ev.tempo = tp; ev.err = e; ev.last = 0;
            byte_events.insert(byte_events.size(), ev);
        endfunction

        function void abandon(mtep_pkg::t_err e);
            phase = mtep_pkg::PH_IDLE;
            emit(mtep_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, e);
        endfunction

        // 0 more bytes, 1 complete, 2 too long
        function int vlq_take(logic [7:0] b);
            vlq_acc = {vlq_acc[20:0], b[6:0]};
            vlq_cnt = (vlq_cnt + 1) & 7;
            if (!b[7]) return 1;
            if (vlq_cnt >= mtep_pkg::VARLEN_MAX_BYTES) return 2;
            return 0;
        endfunction

        function void finish_meta();
            phase = mtep_pkg::PH_DELTA;
            if (meta_kind == mtep_pkg::META_TEMPO) begin
                emit(mtep_pkg::KIND_TEMPO, tick, 0, 0, 0, 0, tempo_acc, mtep_pkg::ERR_NONE);
            end else if (meta_kind == mtep_pkg::META_EOT) begin
                emit(mtep_pkg::KIND_EOT, tick, 0, 0, 0, 0, 0, mtep_pkg::ERR_NONE);
                phase = mtep_pkg::PH_IDLE;
            end
        endfunction

        function void channel_msg(logic [6:0] second);
            logic [10:0] idx;
            logic [31:0] st, d;
            logic [38:0] head;
            int c;
            int base;
            idx = {ev_status[3:0], key_byte};
            c = slot_cnt[idx];
            base = int'(idx) * mtep_pkg::NOTE_QUEUE_DEPTH;
            phase = mtep_pkg::PH_DELTA;
            if (ev_status[7:4] == mtep_pkg::ST_NOTE_ON[7:4] && second != 0) begin
                if (c >= mtep_pkg::NOTE_QUEUE_DEPTH) begin
                    abandon(mtep_pkg::ERR_QUEUE);
                    return;
                end
                slots[base + c] = {second, tick};
                slot_cnt[idx] = c + 1;
            end else if (ev_status[7:4] == mtep_pkg::ST_NOTE_ON[7:4] ||
                         ev_status[7:4] == mtep_pkg::ST_NOTE_OFF[7:4]) begin
                if (c != 0) begin
                    head = slots[base];
                    st = head[31:0];
                    d = tick - st;
                    if (d == 0) d = 1;
                    for (int i = 0; i < c - 1; i++)
                        slots[base + i] = slots[base + i + 1];
                    slot_cnt[idx] = c - 1;
                    emit(mtep_pkg::KIND_NOTE, st, d, ev_status[3:0], key_byte, head[38:32],
                         0, mtep_pkg::ERR_NONE);
                end
            end
        endfunction

        function new();
            errors = 0;
            clear_track();
        endfunction

        // runs the parser on one accepted byte and queues what it should produce
        function void take_byte(logic [7:0] b, logic ts, logic te);
            int v;
            byte_events.delete();
            if (ts) clear_track();
            case (phase)
                mtep_pkg::PH_DELTA: begin
                    v = vlq_take(b);
                    if (v == 2) abandon(mtep_pkg::ERR_LONG_VLQ);
                    else if (v == 1) begin
                        tick = tick + {4'd0, vlq_acc};
                        vlq_acc = 0; vlq_cnt = 0;
                        phase = mtep_pkg::PH_STATUS;
                    end
                end
                mtep_pkg::PH_STATUS: begin
                    if (!b[7]) begin
                        if (run_status == 0) abandon(mtep_pkg::ERR_NO_STATUS);
                        else begin
                            ev_status = run_status;
                            key_byte = b[6:0];
                            if (ev_status[7:5] == mtep_pkg::ST_PROGRAM[7:5]) channel_msg(0);
                            else phase = mtep_pkg::PH_DATA2;
                        end
                    end else if (b < mtep_pkg::ST_SYSEX) begin
                        run_status = b;
                        ev_status = b;
                        phase = mtep_pkg::PH_DATA1;
                    end else if (b == mtep_pkg::ST_META) begin
                        run_status = 0;
                        phase = mtep_pkg::PH_MTYPE;
                    end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
                        run_status = 0;
                        phase = mtep_pkg::PH_SLEN;
                    end else abandon(mtep_pkg::ERR_SYSTEM);
                end
                mtep_pkg::PH_DATA1: begin
                    key_byte = b[6:0];
                    if (ev_status[7:5] == mtep_pkg::ST_PROGRAM[7:5]) channel_msg(0);
                    else phase = mtep_pkg::PH_DATA2;
                end
                mtep_pkg::PH_DATA2: channel_msg(b[6:0]);
                mtep_pkg::PH_MTYPE: begin
                    meta_kind = b;
                    phase = mtep_pkg::PH_MLEN;
                end
                mtep_pkg::PH_MLEN: begin
                    v = vlq_take(b);
                    if (v == 2) abandon(mtep_pkg::ERR_LONG_VLQ);
                    else if (v == 1) begin
                        skip_left = vlq_acc;
                        vlq_acc = 0; vlq_cnt = 0;
                        if (meta_kind == mtep_pkg::META_TEMPO && skip_left != 3) meta_kind = 0;
                        tempo_acc = 0;
                        if (skip_left == 0) finish_meta();
                        else phase = mtep_pkg::PH_MDATA;
                    end
                end
                mtep_pkg::PH_MDATA: begin
                    tempo_acc = {tempo_acc[15:0], b};
                    skip_left = skip_left - 1;
                    if (skip_left == 0) finish_meta();
                end
                mtep_pkg::PH_SLEN: begin
                    v = vlq_take(b);
                    if (v == 2) abandon(mtep_pkg::ERR_LONG_VLQ);
                    else if (v == 1) begin
                        skip_left = vlq_acc;
                        vlq_acc = 0; vlq_cnt = 0;
                        phase = (skip_left == 0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SDATA;
                    end
                end
                mtep_pkg::PH_SDATA: begin
                    skip_left = skip_left - 1;
                    if (skip_left == 0) phase = mtep_pkg::PH_DELTA;
                end
                default: phase = mtep_pkg::PH_IDLE;
            endcase
            if (te) begin
                if (phase != mtep_pkg::PH_IDLE && !(phase == mtep_pkg::PH_DELTA && vlq_cnt == 0))
                    abandon(mtep_pkg::ERR_TRUNCATED);
                phase = mtep_pkg::PH_IDLE;
            end
            if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1;
            foreach (byte_events[i]) pending_events.insert(pending_events.size(), byte_events[i]);
        endfunction

        function void match_event(t_event got);
            t_event exp;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event kind %0d err %0d", $time, got.kind, got.err);
                errors++;
                return;
            end
            exp = pending_events.pop_front();
            if (got !== exp) begin
                $display("%0t: expected kind %0d tick %0d dur %0d ch %0d key %0d vel %0d",
                         $time, exp.kind, exp.start_tick, exp.duration, exp.channel, exp.key,
                         exp.velocity);
                $display("%0t: expected tempo %0d err %0d last %0d",
                         $time, exp.tempo, exp.err, exp.last);
                $display("%0t: actual   kind %0d tick %0d dur %0d ch %0d key %0d vel %0d",
                         $time, got.kind, got.start_tick, got.duration, got.channel, got.key,
                         got.velocity);
                $display("%0t: actual   tempo %0d err %0d last %0d",
                         $time, got.tempo, got.err, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    mtep_in_if  in_if();
    mtep_out_if out_if();

    midi_track_event_parser_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    track_scoreboard sb = new();
    t_byte stream [$];
    bit    quiet = 0;
    int    stall_left = 0;
    int    sent = 0;
    bit    have_status;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // output side: check each transfer, stall in random bursts
    always @(posedge i_clk) begin
        t_event got;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.kind = mtep_pkg::t_kind'(out_if.kind);
            got.start_tick = out_if.start_tick;
            got.duration = out_if.duration_ticks;
            got.channel = out_if.channel_number;
            got.key = out_if.note_number;
            got.velocity = out_if.velocity;
            got.tempo = out_if.tempo_micros;
            got.err = mtep_pkg::t_err'(out_if.fault_code);
            got.last = out_if.last_of_run;
            sb.match_event(got);
        end
        if (i_rst_n !== 1'b1) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic add(input logic [7:0] b, input logic ts = 0, input logic te = 0);
        t_byte s;
        s.b = b; s.ts = ts; s.te = te;
        stream.insert(stream.size(), s);
    endtask

    task automatic add_vlq(input int n);
        for (int i = 1; i < n; i++) add(8'h80 | 8'($urandom_range(0, 127)));
        add(8'($urandom_range(0, 127)));
    endtask

    task automatic add_data(input logic [6:0] v);
        // bit 7 of data bytes is masked off by the block
        add({1'($urandom_range(0, 4) == 0), v});
    endtask

    function automatic logic [7:0] pick_channel_key(output logic [6:0] key);
        key = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'(60 + $urandom_range(0, 2));
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 15))
                                           : 8'($urandom_range(0, 1));
    endfunction

    task automatic add_note(input logic [7:0] op, input logic [6:0] vel);
        logic [6:0] key;
        logic [7:0] ch;
        ch = pick_channel_key(key);
        if (!(have_status && $urandom_range(0, 2) == 0)) add(op | ch);
        have_status = 1;
        add_data(key);
        add_data(vel);
    endtask

    task automatic build_track();
        int n_ev, r, cut;
        n_ev = $urandom_range(5, 40);
        have_status = 0;
        for (int e = 0; e < n_ev; e++) begin
            r = $urandom_range(0, 99);
            if (r < 2) add_vlq(5);
            else add_vlq(($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 4));
            r = $urandom_range(0, 99);
            if (r < 35) add_note(mtep_pkg::ST_NOTE_ON, 7'($urandom_range(1, 127)));
            else if (r < 60) begin
                if ($urandom_range(0, 1)) add_note(mtep_pkg::ST_NOTE_OFF, 7'($urandom));
                else add_note(mtep_pkg::ST_NOTE_ON, 7'd0);
            end else if (r < 68) begin
                r = $urandom_range(8'ha0, 8'hef);
                add(8'(r));
                have_status = 1;
                add_data(7'($urandom));
                if (r[7:5] != mtep_pkg::ST_PROGRAM[7:5]) add_data(7'($urandom));
            end else if (r < 76) begin
                add(mtep_pkg::ST_META); add(mtep_pkg::META_TEMPO); add(8'd3);
                repeat (3) add(8'($urandom));
                have_status = 0;
            end else if (r < 87) begin
                if (r < 82) begin
                    add(mtep_pkg::ST_META);
                    add(($urandom_range(0, 3) == 0) ? mtep_pkg::META_TEMPO
                                                    : 8'($urandom_range(0, 8'h2e)));
                end else add($urandom_range(0, 1) ? mtep_pkg::ST_SYSEX
                                                  : mtep_pkg::ST_SYSEX_ESC);
                r = $urandom_range(0, 4);
                add(8'(r));
                repeat (r) add(8'($urandom));
                have_status = 0;
            end else if (r < 89) begin
                add(mtep_pkg::ST_META); add(mtep_pkg::META_EOT); add(8'd0);
            end else if (r < 91) add(8'($urandom));
            else if (r < 93) begin
                r = $urandom_range(0, 12);
                add(8'(r < 6 ? 8'hf1 + r : 8'hf8 + r - 6));
            end else add(8'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, 3);
            repeat (cut) if (stream.size() > 1) void'(stream.pop_back());
        end
        stream[stream.size() - 1].te = 1;
    endtask

    task automatic send_byte(input t_byte s);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= s.b;
        in_if.track_start <= s.ts;
        in_if.track_end <= s.te;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        sb.take_byte(s.b, s.ts, s.te);
        sent++;
    endtask

    task automatic send_stream();
        while (stream.size() > 0) send_byte(stream.pop_front());
    endtask

    initial begin
        #50_000_000;
        $display("midi_track_event_parser_core: mismatch");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data_byte <= 8'd0;
        in_if.track_start <= 1'b0;
        in_if.track_end <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bytes before any track start: note pair, velocity 0x80 as note-off
        add(8'h00); add(mtep_pkg::ST_NOTE_ON); add(8'h3c); add(8'h40);
        add(8'h81); add(8'h00); add(8'h3c); add(8'h80);
        // tempo, then widest delta, an unmatched note-off and a system byte
        add(8'h00); add(mtep_pkg::ST_META); add(mtep_pkg::META_TEMPO); add(8'h03);
        add(8'h07); add(8'ha1); add(8'h20);
        add(8'hff); add(8'hff); add(8'hff); add(8'h7f);
        add(mtep_pkg::ST_NOTE_OFF); add(8'h3c); add(8'h00);
        add(8'h00); add(8'hf1);
        // data byte with no running status
        add(8'h00, 1); add(8'h3c);
        // delta longer than four bytes
        add(8'hff, 1); add(8'hff); add(8'hff); add(8'hff);
        // cut inside a program change
        add(8'h00, 1); add(8'hc5, 0, 1);
        // end of track, then the last byte
        add(8'h00, 1); add(mtep_pkg::ST_META); add(mtep_pkg::META_EOT); add(8'h00, 0, 1);
        send_stream();

        // hold off until every result is out
        in_if.valid <= 1'b0;
        while (sb.pending_events.size() > 0) @(posedge i_clk);

        while (sent < 1630) begin
            if (sent > 1330) quiet = 1;
            build_track();
            stream[0].ts = 1;
            send_stream();
        end
        in_if.valid <= 1'b0;
        while (sb.pending_events.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("midi_track_event_parser_core: match");
        else
            $display("midi_track_event_parser_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
